/* rtl/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_LIST       = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ITEM  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

endpackage

/* rtl/deq_mem.sv */
module deq_mem #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [deq_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [deq_pkg::DATA_W-1:0] rdata
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/deq_ctrl.sv */
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int OW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [deq_pkg::KIND_W-1:0]  in_kind,
  input  logic [deq_pkg::DATA_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [deq_pkg::DATA_W-1:0]  out_element,
  output logic [deq_pkg::STATUS_W-1:0] out_status,
  output logic                        out_last,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [deq_pkg::DATA_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [deq_pkg::DATA_W-1:0]  mem_rdata
);

  localparam int SW = OW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  deq_pkg::state_t state, state_next;
  logic [AW-1:0] front, front_next;
  logic [OW-1:0] occ, occ_next;
  logic [OW-1:0] cnt, cnt_next;
  logic          rd_pend, rd_pend_next;
  logic          out_valid_next;
  logic [deq_pkg::DATA_W-1:0]   out_element_next;
  logic [deq_pkg::STATUS_W-1:0] out_status_next;
  logic                         out_last_next;

  logic          slot_free;
  logic          accept;
  logic [SW-1:0] back_sum, list_sum;
  logic [AW-1:0] back_idx, list_idx;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == deq_pkg::S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  // wrap front plus offset into the ring
  assign back_sum = SW'(front) + SW'(occ);
  assign list_sum = SW'(front) + SW'(cnt);
  assign back_idx = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign list_idx = (list_sum >= DEPTH_S) ? AW'(list_sum - DEPTH_S) : AW'(list_sum);

  always_comb begin
    state_next       = state;
    front_next       = front;
    occ_next         = occ;
    cnt_next         = cnt;
    rd_pend_next     = rd_pend;
    out_valid_next   = out_valid && !out_ready;
    out_element_next = out_element;
    out_status_next  = out_status;
    out_last_next    = out_last;
    mem_we           = 1'b0;
    mem_waddr        = front;
    mem_wdata        = in_value;
    mem_re           = 1'b0;
    mem_raddr        = list_idx;

    case (state)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          out_element_next = '0;
          out_last_next    = 1'b1;
          out_status_next  = deq_pkg::ST_DONE;
          case (in_kind)
            deq_pkg::K_PUSH_FRONT: begin
              out_valid_next = 1'b1;
              if (occ == FULL_OCC) begin
                out_status_next = deq_pkg::ST_FULL;
              end else begin
                front_next = (front == '0) ? LAST_IDX : front - AW'(1);
                mem_we     = 1'b1;
                mem_waddr  = front_next;
                occ_next   = occ + OW'(1);
              end
            end
            deq_pkg::K_PUSH_BACK: begin
              out_valid_next = 1'b1;
              if (occ == FULL_OCC) begin
                out_status_next = deq_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_idx;
                occ_next  = occ + OW'(1);
              end
            end
            deq_pkg::K_POP_FRONT: begin
              out_valid_next = 1'b1;
              if (occ == '0) begin
                out_status_next = deq_pkg::ST_EMPTY;
              end else begin
                front_next = (front == LAST_IDX) ? '0 : front + AW'(1);
                occ_next   = occ - OW'(1);
              end
            end
            deq_pkg::K_POP_BACK: begin
              out_valid_next = 1'b1;
              if (occ == '0) begin
                out_status_next = deq_pkg::ST_EMPTY;
              end else begin
                occ_next = occ - OW'(1);
              end
            end
            deq_pkg::K_LIST: begin
              state_next   = deq_pkg::S_LIST;
              cnt_next     = '0;
              rd_pend_next = 1'b0;
            end
            default: begin
              // unused kinds: drop
            end
          endcase
        end
      end
      deq_pkg::S_LIST: begin
        if (rd_pend && slot_free) begin
          out_valid_next   = 1'b1;
          out_element_next = mem_rdata;
          out_status_next  = deq_pkg::ST_ITEM;
          out_last_next    = 1'b0;
          rd_pend_next     = 1'b0;
        end
        if (cnt < occ) begin
          if (!rd_pend || slot_free) begin
            mem_re       = 1'b1;
            cnt_next     = cnt + OW'(1);
            rd_pend_next = 1'b1;
          end
        end else if (!rd_pend && slot_free) begin
          out_valid_next   = 1'b1;
          out_element_next = '0;
          out_status_next  = deq_pkg::ST_DONE;
          out_last_next    = 1'b1;
          state_next       = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::S_IDLE;
      front     <= '0;
      occ       <= '0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      occ       <= occ_next;
      cnt       <= cnt_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_element <= out_element_next;
    out_status  <= out_status_next;
    out_last    <= out_last_next;
  end

endmodule

/* rtl/double_ended_queue_unit.sv */
// Channel  Dir  Beat carries
// s_*      in   tuser[2:0] kind, tdata[31:0] value
// m_*      out  tdata[31:0] element, tuser[1:0] status, tlast last
//
// Push or pop: once accepted (a push that fits makes one memory write), the
// status beat sits in the output register from the next cycle on.
// List of n elements: one registered read per cycle while the output is not
// stalled; each read's data goes out as an item beat, then the closing beat
// (alone when empty) is loaded as the state returns to idle.
// rst clears front index, occupancy and control; the store needs no clear.
// A waiting output beat blocks s_tready until m_tready takes it; during a
// list a stall on m_tready also holds the pending read.
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [7:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] element
  output logic [7:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [deq_pkg::DATA_W-1:0]   mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [deq_pkg::DATA_W-1:0]   mem_rdata;
  logic [deq_pkg::STATUS_W-1:0] status;

  deq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .OW   (OW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser[deq_pkg::KIND_W-1:0]),
    .in_value   (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_element(m_tdata),
    .out_status (status),
    .out_last   (m_tlast),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  deq_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign m_tuser = {6'b0, status};

endmodule

/* tb/tb_top.sv */
module tb_top;
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int N_ITEMS = 410;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_LAST = 3'd7;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [31:0] value;
    bit drain_first;
  } deq_op_t;

  typedef struct {
    logic [31:0] element;
    status_t status;
    logic last;
  } deq_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic [7:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [7:0] m_tuser;
  logic m_tlast;

  double_ended_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  deq_op_t ops_pending[$];
  deq_beat_t due_beats[$];
  int errors = 0;
  logic [31:0] cyc = '0;

  // shadow deque
  logic [31:0] shadow_mem[DEPTH];
  int head_idx = 0;
  int fill_cnt = 0;

  // occupancy as seen by the stimulus generator
  int gen_fill = 0;
  int gen_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // Most gaps short, a few long; gaps are zero whenever cyc[9:8] is zero.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (cyc[9:8] == 2'b00) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void expect_beat(logic [31:0] e, status_t s, logic l);
    deq_beat_t b;
    b.element = e;
    b.status = s;
    b.last = l;
    due_beats.push_back(b);
  endfunction

  function automatic void apply_op(deq_op_t op);
    int i;
    case (op.kind)
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (fill_cnt >= DEPTH) begin
          expect_beat('0, ST_FULL, 1'b1);
        end else begin
          if (op.kind == K_PUSH_FRONT) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            shadow_mem[head_idx] = op.value;
          end else begin
            shadow_mem[(head_idx + fill_cnt) % DEPTH] = op.value;
          end
          fill_cnt++;
          expect_beat('0, ST_DONE, 1'b1);
        end
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (fill_cnt == 0) begin
          expect_beat('0, ST_EMPTY, 1'b1);
        end else begin
          if (op.kind == K_POP_FRONT) head_idx = (head_idx + 1) % DEPTH;
          fill_cnt--;
          expect_beat('0, ST_DONE, 1'b1);
        end
      end
      K_LIST: begin
        for (i = 0; i < fill_cnt; i++)
          expect_beat(shadow_mem[(head_idx + i) % DEPTH], ST_ITEM, 1'b0);
        expect_beat('0, ST_DONE, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_op(logic [KIND_W-1:0] k, logic [31:0] v, bit hold = 1'b0);
    deq_op_t op;
    op.kind = k;
    op.value = v;
    op.drain_first = hold;
    ops_pending.push_back(op);
    if (k == K_PUSH_FRONT || k == K_PUSH_BACK) begin
      if (gen_fill < DEPTH) gen_fill++;
    end else if (k == K_POP_FRONT || k == K_POP_BACK) begin
      if (gen_fill > 0) gen_fill--;
    end
    if (k <= K_LIST) gen_count++;
  endfunction

  function automatic void fill_burst();
    int n;
    n = DEPTH - gen_fill + $urandom_range(1, 3);
    repeat (n) add_op($urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT, rand_word());
  endfunction

  function automatic void drain_burst();
    int n;
    n = gen_fill + $urandom_range(1, 3);
    repeat (n) add_op($urandom_range(0, 1) ? K_POP_BACK : K_POP_FRONT, '0);
  endfunction

  function automatic logic [KIND_W-1:0] rand_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return K_PUSH_FRONT;
    if (r < 44) return K_PUSH_BACK;
    if (r < 62) return K_POP_FRONT;
    if (r < 80) return K_POP_BACK;
    if (r < 90) return K_LIST;
    return KIND_W'($urandom_range(K_SPARE_FIRST, K_SPARE_LAST));
  endfunction

  // stimulus
  initial begin
    int r;
    bit held;
    held = 1'b0;

    add_op(K_LIST, $urandom);
    add_op(K_POP_FRONT, '0);
    add_op(K_POP_BACK, '1);
    add_op(K_PUSH_FRONT, 32'h8000_0000);
    add_op(K_PUSH_BACK, 32'h7fff_ffff);
    add_op(K_PUSH_FRONT, 32'h0000_0000);
    add_op(K_PUSH_BACK, 32'hffff_ffff);
    add_op(K_LIST, '0);
    add_op(K_POP_FRONT, '0);
    add_op(K_POP_BACK, '0);
    add_op(K_LIST, '1);
    add_op(K_SPARE_FIRST, 32'hffff_ffff);
    add_op(K_SPARE_FIRST + 3'd1, 32'h5555_5555);
    add_op(K_SPARE_LAST, 32'haaaa_aaaa);
    add_op(K_PUSH_FRONT, 32'h5555_5555, 1'b1);
    add_op(K_PUSH_BACK, 32'haaaa_aaaa);
    add_op(K_LIST, '0);
    add_op(K_POP_FRONT, '0);
    add_op(K_POP_FRONT, '0);
    add_op(K_POP_FRONT, '0);
    add_op(K_POP_BACK, '0);
    add_op(K_POP_BACK, '0);
    add_op(K_LIST, '0);

    // reach full and empty early, then mix
    fill_burst();
    add_op(K_LIST, $urandom);
    drain_burst();

    while (gen_count < N_ITEMS) begin
      r = $urandom_range(0, 9);
      if (!held && gen_count > N_ITEMS / 2) begin
        add_op(K_LIST, $urandom, 1'b1);
        held = 1'b1;
      end else if (r < 2) begin
        fill_burst();
        if ($urandom_range(0, 1)) add_op(K_LIST, $urandom);
      end else if (r < 4) begin
        drain_burst();
      end else if (r == 4) begin
        add_op(K_LIST, $urandom);
      end else begin
        repeat ($urandom_range(3, 10)) add_op(rand_kind(), rand_word());
      end
    end

    @(posedge clk);
    while (ops_pending.size() != 0 || s_tvalid || due_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, due_beats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver
  deq_op_t cur_op;
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) apply_op(cur_op);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (ops_pending.size() != 0 &&
                     !(ops_pending[0].drain_first && due_beats.size() != 0)) begin
          cur_op = ops_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= cur_op.value;
          s_tuser <= {5'b0, cur_op.kind};
          send_gap = gap_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;

  always @(posedge clk) begin
    deq_beat_t exp_beat;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat element=%h status=%0d last=%b",
                   $time, m_tdata, m_tuser[1:0], m_tlast);
          errors++;
        end else begin
          exp_beat = due_beats.pop_front();
          if (m_tdata !== exp_beat.element) begin
            $display("%0t: element expected %h actual %h", $time, exp_beat.element, m_tdata);
            errors++;
          end
          if (m_tuser[1:0] !== exp_beat.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_beat.status, m_tuser[1:0]);
            errors++;
          end
          if (m_tlast !== exp_beat.last) begin
            $display("%0t: last expected %b actual %b", $time, exp_beat.last, m_tlast);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = gap_len();
      end
    end
  end

  // watchdog: count cycles with no beat on either side
  int idle_cyc = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
rtl/deq_pkg.sv
rtl/deq_mem.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_unit.sv
tb/tb_top.sv
